// ===== rtl/core/apr_pkg.sv =====
// Package for the aging page replacement block.
// Shared constants and the chain/update structs used by the cells and the top level.
// No dependencies.
package apr_pkg;

  localparam int unsigned FRAMES_DEF    = 8;
  localparam int unsigned PAGE_BITS_DEF = 16;

  localparam int unsigned AGE_W     = 8;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned FIDX_W    = 3;
  localparam int unsigned EV_PAGE_W = 16;

  localparam logic [AGE_W-1:0] AGE_TOP   = 8'h80;
  localparam logic [AGE_W-1:0] AGE_MAX   = 8'hFF;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

  // flags handed from cell to cell
  typedef struct packed {
    logic hit;
    logic empty;
    logic best_vld;
  } chn_t;

  // update broadcast to every cell
  typedef struct packed {
    logic en;
    logic hit;
    logic fill;
  } upd_t;

endpackage

// ===== rtl/core/apr_cell.sv =====
// One frame cell: page, valid bit and age counter for a single frame.
// Refines the running hit / empty / oldest search handed along the chain.
// Depends on apr_pkg.
module apr_cell #(
  parameter int unsigned IDX       = 0,
  parameter int unsigned IDX_W     = 3,
  parameter int unsigned PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [apr_pkg::CFG_W-1:0]   cfg_frames_i,
  input  logic [PAGE_BITS-1:0]        page_i,
  input  apr_pkg::upd_t               upd_i,
  input  logic [IDX_W-1:0]            upd_idx_i,
  input  apr_pkg::chn_t               flg_i,
  input  logic [IDX_W-1:0]            hit_idx_i,
  input  logic [IDX_W-1:0]            empty_idx_i,
  input  logic [apr_pkg::AGE_W-1:0]   best_age_i,
  input  logic [IDX_W-1:0]            best_idx_i,
  input  logic [PAGE_BITS-1:0]        best_page_i,
  output apr_pkg::chn_t               flg_o,
  output logic [IDX_W-1:0]            hit_idx_o,
  output logic [IDX_W-1:0]            empty_idx_o,
  output logic [apr_pkg::AGE_W-1:0]   best_age_o,
  output logic [IDX_W-1:0]            best_idx_o,
  output logic [PAGE_BITS-1:0]        best_page_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [PAGE_BITS-1:0]      page_q;
  logic                      valid_q;
  logic [apr_pkg::AGE_W-1:0] age_q;
  logic [apr_pkg::AGE_W-1:0] age_sh;
  logic                      in_use;
  logic                      match;
  logic                      is_empty;
  logic                      older;
  logic                      sel;

  // frame 0 always takes part, so a setting of zero acts as one
  assign in_use   = (IDX == 0) || (32'(cfg_frames_i) > IDX);
  assign age_sh   = age_q >> 1;
  assign match    = in_use && valid_q && (page_q == page_i);
  assign is_empty = in_use && !valid_q;
  assign older    = in_use && (!flg_i.best_vld || (age_sh < best_age_i));
  assign sel      = (upd_idx_i == MY_IDX);

  always_comb begin
    flg_o.hit      = flg_i.hit | match;
    flg_o.empty    = flg_i.empty | is_empty;
    flg_o.best_vld = flg_i.best_vld | older;
    hit_idx_o      = flg_i.hit ? hit_idx_i : MY_IDX;
    empty_idx_o    = flg_i.empty ? empty_idx_i : MY_IDX;
    best_age_o     = older ? age_sh : best_age_i;
    best_idx_o     = older ? MY_IDX : best_idx_i;
    best_page_o    = older ? page_q : best_page_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      age_q   <= '0;
    end else if (upd_i.en) begin
      if (upd_i.fill && sel) begin
        valid_q <= 1'b1;
        age_q   <= apr_pkg::AGE_TOP;
      end else if (upd_i.hit && sel) begin
        age_q <= age_sh | apr_pkg::AGE_TOP;
      end else begin
        age_q <= age_sh;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
    end else if (upd_i.en && upd_i.fill && sel) begin
      page_q <= page_i;
    end
  end

endmodule

// ===== rtl/core/aging_page_replacement.sv =====
// Channel   | signals                                   | dir
// ----------+-------------------------------------------+-----
// cfg       | cfg_valid_i, cfg_ready_o, frames_in_use_i | in
// in        | in_valid_i, in_ready_o, page_number_i     | in
// out       | out_valid_o, out_ready_i, fault_o,        | out
//           | frame_index_o, evicted_valid_o, evicted_page_o
//
// One word per cycle while the output is not stalled: the lookup runs through the cell chain in the accept cycle,
// and the result is registered into the output register at the close of that cycle.
// Reset clears all frames and ages and sets frames in use to eight.
// A stalled output word holds; a new word is still taken when the register drains.
// Top level of the aging page replacement block; depends on apr_pkg and apr_cell.
module aging_page_replacement #(
  parameter int unsigned FRAMES    = apr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = apr_pkg::PAGE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [apr_pkg::CFG_W-1:0]       frames_in_use_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [PAGE_BITS-1:0]            page_number_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            fault_o,
  output logic [apr_pkg::FIDX_W-1:0]      frame_index_o,
  output logic                            evicted_valid_o,
  output logic [apr_pkg::EV_PAGE_W-1:0]   evicted_page_o
);

  localparam int unsigned IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [apr_pkg::CFG_W-1:0] frames_q;

  apr_pkg::chn_t             flg       [FRAMES+1];
  logic [IDX_W-1:0]          hit_idx   [FRAMES+1];
  logic [IDX_W-1:0]          empty_idx [FRAMES+1];
  logic [apr_pkg::AGE_W-1:0] best_age  [FRAMES+1];
  logic [IDX_W-1:0]          best_idx  [FRAMES+1];
  logic [PAGE_BITS-1:0]      best_page [FRAMES+1];

  apr_pkg::upd_t             upd;
  logic [IDX_W-1:0]          slot_idx;
  logic                      accept;
  logic                      evict;
  logic [apr_pkg::FIDX_W-1:0]    fidx;
  logic [apr_pkg::EV_PAGE_W-1:0] ev_page;

  logic                          out_valid_q;
  logic                          fault_q;
  logic [apr_pkg::FIDX_W-1:0]    fidx_q;
  logic                          ev_valid_q;
  logic [apr_pkg::EV_PAGE_W-1:0] ev_page_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= apr_pkg::CFG_RESET;
    end else if (cfg_valid_i) begin
      frames_q <= frames_in_use_i;
    end
  end

  assign flg[0]       = '0;
  assign hit_idx[0]   = '0;
  assign empty_idx[0] = '0;
  assign best_age[0]  = apr_pkg::AGE_MAX;
  assign best_idx[0]  = '0;
  assign best_page[0] = '0;

  for (genvar j = 0; j < FRAMES; j++) begin : g_cell
    apr_cell #(
      .IDX       (j),
      .IDX_W     (IDX_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cfg_frames_i (frames_q),
      .page_i       (page_number_i),
      .upd_i        (upd),
      .upd_idx_i    (slot_idx),
      .flg_i        (flg[j]),
      .hit_idx_i    (hit_idx[j]),
      .empty_idx_i  (empty_idx[j]),
      .best_age_i   (best_age[j]),
      .best_idx_i   (best_idx[j]),
      .best_page_i  (best_page[j]),
      .flg_o        (flg[j+1]),
      .hit_idx_o    (hit_idx[j+1]),
      .empty_idx_o  (empty_idx[j+1]),
      .best_age_o   (best_age[j+1]),
      .best_idx_o   (best_idx[j+1]),
      .best_page_o  (best_page[j+1])
    );
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    upd.en   = accept;
    upd.hit  = flg[FRAMES].hit;
    upd.fill = !flg[FRAMES].hit;
    evict    = !flg[FRAMES].hit && !flg[FRAMES].empty;
    if (flg[FRAMES].hit) begin
      slot_idx = hit_idx[FRAMES];
    end else if (flg[FRAMES].empty) begin
      slot_idx = empty_idx[FRAMES];
    end else begin
      slot_idx = best_idx[FRAMES];
    end
  end

  if (IDX_W >= apr_pkg::FIDX_W) begin : g_fidx_cut
    assign fidx = slot_idx[apr_pkg::FIDX_W-1:0];
  end else begin : g_fidx_ext
    assign fidx = apr_pkg::FIDX_W'(slot_idx);
  end

  if (PAGE_BITS >= apr_pkg::EV_PAGE_W) begin : g_page_cut
    assign ev_page = best_page[FRAMES][apr_pkg::EV_PAGE_W-1:0];
  end else begin : g_page_ext
    assign ev_page = apr_pkg::EV_PAGE_W'(best_page[FRAMES]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fault_q    <= upd.fill;
      fidx_q     <= fidx;
      ev_valid_q <= evict;
      ev_page_q  <= evict ? ev_page : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign fault_o         = fault_q;
  assign frame_index_o   = fidx_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;

endmodule

// ===== rtl/core/apr_checker.sv =====
// Port-level checks for aging_page_replacement, bound to the top level.
// Depends on apr_pkg and aging_page_replacement.
module apr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          fault_o,
  input logic                          evicted_valid_o,
  input logic [apr_pkg::EV_PAGE_W-1:0] evicted_page_o
);

  // stalled output word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // an empty output register never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output register");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fault_o |-> !evicted_valid_o && (evicted_page_o == '0))
    else $error("eviction reported on a hit");

  // no eviction, no page
  a_ev_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_valid_o |-> (evicted_page_o == '0))
    else $error("evicted page without eviction");

  // an accepted word shows up in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing after accept");

endmodule

bind aging_page_replacement apr_checker u_apr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .fault_o         (fault_o),
  .evicted_valid_o (evicted_valid_o),
  .evicted_page_o  (evicted_page_o)
);

// ===== test/tb_aging_page_replacement.sv =====
// Self-checking testbench for aging_page_replacement: a table of directed words, then random
// reference streams across frames_in_use settings, checked against a local aging predictor.
// Depends on apr_pkg and the aging_page_replacement RTL.
`timescale 1ns / 100ps

module tb_aging_page_replacement;

  localparam int unsigned NFRAMES     = apr_pkg::FRAMES_DEF;
  localparam int          WATCH_LIMIT = 3000;
  localparam int          PHASES      = 22;
  localparam int          PHASE_ITEMS = 61;

  typedef struct packed {
    logic                          fault;
    logic [apr_pkg::FIDX_W-1:0]    frame;
    logic                          ev_vld;
    logic [apr_pkg::EV_PAGE_W-1:0] ev_page;
  } page_result_t;

  typedef struct packed {
    logic         typed;
    page_result_t want;
  } fixed_answer_t;

  typedef enum logic {ROW_CFG, ROW_REF} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic [15:0]  value;
    logic         typed;
    page_result_t want;
  } dir_row_t;

  // kind, page or frames_in_use, typed, {fault, frame, evicted_valid, evicted_page}
  localparam dir_row_t DIR_TAB [27] = '{
    {ROW_REF, 16'h0001, 1'b1, 1'b1, 3'd0, 1'b0, 16'h0000},
    {ROW_REF, 16'hFFFF, 1'b1, 1'b1, 3'd1, 1'b0, 16'h0000},
    {ROW_REF, 16'h0001, 1'b1, 1'b0, 3'd0, 1'b0, 16'h0000},
    {ROW_REF, 16'h0000, 1'b1, 1'b1, 3'd2, 1'b0, 16'h0000},
    {ROW_REF, 16'h0000, 1'b1, 1'b0, 3'd2, 1'b0, 16'h0000},
    {ROW_REF, 16'h8000, 1'b1, 1'b1, 3'd3, 1'b0, 16'h0000},
    {ROW_REF, 16'h7FFF, 1'b1, 1'b1, 3'd4, 1'b0, 16'h0000},
    {ROW_REF, 16'h5555, 1'b1, 1'b1, 3'd5, 1'b0, 16'h0000},
    {ROW_REF, 16'hAAAA, 1'b1, 1'b1, 3'd6, 1'b0, 16'h0000},
    {ROW_REF, 16'h1234, 1'b1, 1'b1, 3'd7, 1'b0, 16'h0000},
    {ROW_REF, 16'h0F0F, 1'b0, 21'h0},
    {ROW_CFG, 16'd1,    1'b0, 21'h0},
    {ROW_REF, 16'h00FF, 1'b0, 21'h0},
    {ROW_REF, 16'h00FF, 1'b0, 21'h0},
    {ROW_CFG, 16'd0,    1'b0, 21'h0},
    {ROW_REF, 16'h4321, 1'b0, 21'h0},
    {ROW_CFG, 16'd15,   1'b0, 21'h0},
    {ROW_REF, 16'h0000, 1'b0, 21'h0},
    {ROW_CFG, 16'd3,    1'b0, 21'h0},
    {ROW_REF, 16'h0101, 1'b0, 21'h0},
    {ROW_REF, 16'h0202, 1'b0, 21'h0},
    {ROW_REF, 16'h0303, 1'b0, 21'h0},
    {ROW_REF, 16'h0404, 1'b0, 21'h0},
    {ROW_CFG, 16'd9,    1'b0, 21'h0},
    {ROW_REF, 16'hFFFF, 1'b0, 21'h0},
    {ROW_CFG, 16'd8,    1'b0, 21'h0},
    {ROW_REF, 16'h1234, 1'b0, 21'h0}
  };

  localparam logic [apr_pkg::CFG_W-1:0] CFG_CORNERS [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [apr_pkg::CFG_W-1:0]     frames_in_use_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [15:0]                   page_number_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          fault_o;
  logic [apr_pkg::FIDX_W-1:0]    frame_index_o;
  logic                          evicted_valid_o;
  logic [apr_pkg::EV_PAGE_W-1:0] evicted_page_o;

  // predictor state
  logic [15:0]               frame_page [NFRAMES];
  logic                      frame_vld  [NFRAMES];
  logic [apr_pkg::AGE_W-1:0] frame_age  [NFRAMES];
  logic [apr_pkg::CFG_W-1:0] cfg_frames = apr_pkg::CFG_RESET;

  page_result_t  awaited_results [$];
  fixed_answer_t fixed_answers [$];

  int n_errors, n_items, n_hits, n_faults, n_evicts, n_cfg;
  int quiet_cycles;
  int tx_idle_pct = 29;
  int rx_idle_pct = 29;
  bit hold_rx;

  aging_page_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .frames_in_use_i (frames_in_use_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_number_i   (page_number_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .fault_o         (fault_o),
    .frame_index_o   (frame_index_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic int active_frames(input logic [apr_pkg::CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > NFRAMES) return NFRAMES;
    return int'(v);
  endfunction

  // age all counters, then hit, fill an empty frame, or evict the oldest
  function automatic page_result_t age_and_place(input logic [15:0] pg);
    int n, j, hit, slot, best;
    page_result_t r;
    n = active_frames(cfg_frames);
    r = '0;
    hit = -1;
    slot = -1;
    for (j = 0; j < NFRAMES; j++) frame_age[j] = frame_age[j] >> 1;
    for (j = 0; j < n; j++)
      if (hit < 0 && frame_vld[j] && frame_page[j] == pg) hit = j;
    if (hit >= 0) begin
      frame_age[hit] = frame_age[hit] | apr_pkg::AGE_TOP;
      r.frame = hit[apr_pkg::FIDX_W-1:0];
      return r;
    end
    for (j = 0; j < n; j++)
      if (slot < 0 && !frame_vld[j]) slot = j;
    if (slot < 0) begin
      best = 0;
      for (j = 1; j < n; j++)
        if (frame_age[j] < frame_age[best]) best = j;
      slot = best;
      r.ev_vld = 1'b1;
      r.ev_page = frame_page[slot];
    end
    frame_page[slot] = pg;
    frame_vld[slot] = 1'b1;
    frame_age[slot] = apr_pkg::AGE_TOP;
    r.fault = 1'b1;
    r.frame = slot[apr_pkg::FIDX_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    n_errors++;
    $display("ERROR @%0t: %s got %0h exp %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : monitor
    page_result_t  seen, want;
    fixed_answer_t fa;
    logic          moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        seen = {fault_o, frame_index_o, evicted_valid_o, evicted_page_o};
        if (awaited_results.size() == 0) begin
          report_mismatch("word with nothing pending", seen, 0);
        end else begin
          want = awaited_results.pop_front();
          if (seen.fault !== want.fault) report_mismatch("fault", seen.fault, want.fault);
          if (seen.frame !== want.frame) report_mismatch("frame_index", seen.frame, want.frame);
          if (seen.ev_vld !== want.ev_vld)
            report_mismatch("evicted_valid", seen.ev_vld, want.ev_vld);
          if (seen.ev_page !== want.ev_page)
            report_mismatch("evicted_page", seen.ev_page, want.ev_page);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        moved = 1'b1;
        cfg_frames = frames_in_use_i;
        n_cfg++;
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        fa = fixed_answers.pop_front();
        want = age_and_place(page_number_i);
        n_items++;
        if (!want.fault) n_hits++;
        if (want.fault) n_faults++;
        if (want.ev_vld) n_evicts++;
        awaited_results.insert(awaited_results.size(), fa.typed ? fa.want : want);
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
    end
  end

  initial begin
    do @(posedge clk_i); while (quiet_cycles < WATCH_LIMIT);
    $display("watchdog: %0d cycles without a handshake", WATCH_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_rx && hold_cnt == 0) hold_cnt = 60;
      if (hold_cnt != 0) begin
        hold_cnt--;
        if (hold_cnt == 0) hold_rx = 1'b0;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_page(input logic [15:0] pg, input logic typed, input page_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    fixed_answers.insert(fixed_answers.size(), fixed_answer_t'{typed, want});
    in_valid_i <= 1'b1;
    page_number_i <= pg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_frames(input logic [apr_pkg::CFG_W-1:0] v);
    drain_results();
    cfg_valid_i <= 1'b1;
    frames_in_use_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [15:0]               pool [12];
    logic [apr_pkg::CFG_W-1:0] cfg_v;
    logic [15:0]               pg;
    int                        pool_n;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    frames_in_use_i = '0;
    in_valid_i = 1'b0;
    page_number_i = '0;
    for (int j = 0; j < NFRAMES; j++) begin
      frame_page[j] = '0;
      frame_vld[j] = 1'b0;
      frame_age[j] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIR_TAB[i]) begin
      if (DIR_TAB[i].kind == ROW_CFG) write_frames(DIR_TAB[i].value[apr_pkg::CFG_W-1:0]);
      else send_page(DIR_TAB[i].value, DIR_TAB[i].typed, DIR_TAB[i].want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 4) cfg_v = CFG_CORNERS[ph];
      else if ($urandom_range(3) == 0) cfg_v = apr_pkg::CFG_W'($urandom_range(15));
      else cfg_v = apr_pkg::CFG_W'($urandom_range(1, NFRAMES));
      write_frames(cfg_v);
      // small working set so hits and evictions both happen often
      pool_n = active_frames(cfg_v) + $urandom_range(4);
      foreach (pool[k])
        pool[k] = ($urandom_range(9) == 0) ? 16'h0 : 16'($urandom_range(16'hFFFF));
      tx_idle_pct = (ph >= 8 && ph <= 11) ? 0 : 29;
      rx_idle_pct = tx_idle_pct;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 5 && k == 20) hold_rx = 1'b1;
        if (ph == 13 && k == 30) drain_results();
        if ($urandom_range(99) < 85) pg = pool[$urandom_range(pool_n - 1)];
        else pg = 16'($urandom_range(16'hFFFF));
        send_page(pg, 1'b0, '0);
      end
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    $display("covered %0d references: %0d hits, %0d faults, %0d evictions",
             n_items, n_hits, n_faults, n_evicts);
    $display("%0d frames_in_use writes, out-of-range values and a long output stall included",
             n_cfg);
    if (n_errors == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
